// ----- sv/rotation_matrix_to_euler_angles_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_EULER_ANGLES_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_EULER_ANGLES_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define RMEA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RMEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rmea_pkg.sv -----
// ----------------------------------------------------------------------------
// rmea_pkg
// Constants and angle table for the rotation matrix to Euler angle converter.
// ----------------------------------------------------------------------------
package rmea_pkg;

    localparam int DATA_WIDTH_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int THR_W             = 15;
    localparam int OUT_W             = 16;
    localparam int ANG_W             = 28;
    localparam int TABLE_LEN         = 24;

    localparam logic [THR_W-1:0] THR_RESET = 15'd1;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 28'sd52707179;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 28'sd26353589;
    localparam logic signed [OUT_W-1:0] OUT_LIMIT   = 16'sd25736;

    typedef logic signed [ANG_W-1:0] ang_t;

    function automatic ang_t atan_entry(input int idx);
        ang_t r;
        r = '0;
        case (idx)
            0:  r = 28'sd13176795;
            1:  r = 28'sd7778716;
            2:  r = 28'sd4110060;
            3:  r = 28'sd2086331;
            4:  r = 28'sd1047214;
            5:  r = 28'sd524117;
            6:  r = 28'sd262123;
            7:  r = 28'sd131069;
            default:
            begin
                if (idx < TABLE_LEN)
                    r = ang_t'(28'sd65536 >>> (idx - 8));
                else
                    r = '0;
            end
        endcase
        return r;
    endfunction

    // Q.24 angle to saturated Q3.13 with round half up.
    function automatic logic signed [OUT_W-1:0] to_q13(input ang_t z);
        logic signed [ANG_W:0] s;
        logic signed [ANG_W-11:0] r;
        s = {z[ANG_W-1], z} + (ANG_W+1)'(1024);
        r = s[ANG_W:11];
        if (r > (ANG_W-10)'(OUT_LIMIT))
            return OUT_LIMIT;
        if (r < -(ANG_W-10)'(OUT_LIMIT))
            return -OUT_LIMIT;
        return OUT_W'(r);
    endfunction

endpackage

// ----- sv/rmea_if.sv -----
// ----------------------------------------------------------------------------
// rmea_if
// Valid/ready channels: matrix input, angle output, threshold write.
// ----------------------------------------------------------------------------
interface rmea_in_if #(parameter int DATA_WIDTH = rmea_pkg::DATA_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    modport source (output valid, m00, m10, m20, m21, m22, m11, m12, input ready);
    modport sink (input valid, m00, m10, m20, m21, m22, m11, m12, output ready);
endinterface

interface rmea_out_if #(parameter int DATA_WIDTH = rmea_pkg::DATA_WIDTH_DEF);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] angle_x;
    logic signed [DATA_WIDTH-1:0] angle_y;
    logic signed [DATA_WIDTH-1:0] angle_z;
    logic                         is_singular;
    modport source (output valid, angle_x, angle_y, angle_z, is_singular, input ready);
    modport sink (input valid, angle_x, angle_y, angle_z, is_singular, output ready);
endinterface

interface rmea_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [rmea_pkg::THR_W-1:0]   singular_threshold;
    modport source (output valid, singular_threshold, input ready);
    modport sink (input valid, singular_threshold, output ready);
endinterface

// ----- sv/rmea_isqrt_stage.sv -----
// ----------------------------------------------------------------------------
// rmea_isqrt_stage
// One restoring step of the integer square root: two radicand bits per stage.
// ----------------------------------------------------------------------------
module rmea_isqrt_stage #(
    parameter int SQ_W = 34,
    parameter int RT_W = 17,
    parameter int STEP = 0
) (
    input  logic [SQ_W-1:0] rem_in,
    input  logic [RT_W-1:0] root_in,
    output logic [SQ_W-1:0] rem_out,
    output logic [RT_W-1:0] root_out
);
    localparam int SH = SQ_W - 2 - 2*STEP;

    logic [SQ_W+1:0] trial;
    logic [SQ_W+1:0] rem_w;

    always_comb
    begin
        trial = ((SQ_W+2)'({root_in, 2'b01})) << SH;
        rem_w = (SQ_W+2)'(rem_in);
        if (rem_w >= trial)
        begin
            rem_out  = SQ_W'(rem_w - trial);
            root_out = {root_in[RT_W-2:0], 1'b1};
        end
        else
        begin
            rem_out  = rem_in;
            root_out = {root_in[RT_W-2:0], 1'b0};
        end
    end
endmodule

// ----- sv/rmea_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// rmea_cordic_stage
// One vectoring CORDIC micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module rmea_cordic_stage #(
    parameter int XY_W = 40,
    parameter int STEP = 0
) (
    input  logic signed [XY_W-1:0]  x_in,
    input  logic signed [XY_W-1:0]  y_in,
    input  rmea_pkg::ang_t          z_in,
    output logic signed [XY_W-1:0]  x_out,
    output logic signed [XY_W-1:0]  y_out,
    output rmea_pkg::ang_t          z_out
);
    localparam rmea_pkg::ang_t ATAN_I = rmea_pkg::atan_entry(STEP);

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[XY_W-1])
        begin
            x_out = x_in + dx;
            y_out = y_in - dy;
            z_out = z_in + ATAN_I;
        end
        else
        begin
            x_out = x_in - dx;
            y_out = y_in + dy;
            z_out = z_in - ATAN_I;
        end
    end
endmodule

// ----- sv/rmea_atan2.sv -----
// ----------------------------------------------------------------------------
// rmea_atan2
// Pipelined atan2: quadrant fold, CORDIC stages (one register each), rounding.
// Enable freezes every stage; the caller tracks valid bits.
// ----------------------------------------------------------------------------
module rmea_atan2 #(
    parameter int IN_W          = 18,
    parameter int CORDIC_STAGES = rmea_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [IN_W-1:0]             y,
    input  logic signed [IN_W-1:0]             x,
    output logic signed [rmea_pkg::OUT_W-1:0]  angle
);
    // Operand gains 16 guard bits, one sign bit and CORDIC growth of two bits.
    localparam int XY_W = IN_W + 16 + 3;
    localparam int NS   = (CORDIC_STAGES < rmea_pkg::TABLE_LEN) ?
                          CORDIC_STAGES : rmea_pkg::TABLE_LEN;

    logic signed [XY_W-1:0] x_reg [NS+1];
    logic signed [XY_W-1:0] y_reg [NS+1];
    rmea_pkg::ang_t         z_reg [NS+1];
    logic signed [rmea_pkg::OUT_W-1:0] angle_reg;

    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    rmea_pkg::ang_t         z_next;
    logic signed [XY_W-1:0] x_ext;
    logic signed [XY_W-1:0] y_ext;

    // Fold into the right half plane; zero cases become fixed-angle bypasses.
    always_comb
    begin
        x_ext = XY_W'(x) <<< 16;
        y_ext = XY_W'(y) <<< 16;
        x_next = x_ext;
        y_next = y_ext;
        z_next = '0;
        if (y == '0)
        begin
            x_next = '0;
            y_next = '0;
            z_next = (x[IN_W-1]) ? rmea_pkg::ANG_PI : '0;
        end
        else if (x == '0)
        begin
            x_next = '0;
            y_next = '0;
            z_next = (y[IN_W-1]) ? -rmea_pkg::ANG_HALF_PI : rmea_pkg::ANG_HALF_PI;
        end
        else if (x[IN_W-1])
        begin
            x_next = -x_ext;
            y_next = -y_ext;
            z_next = (y[IN_W-1]) ? -rmea_pkg::ANG_PI : rmea_pkg::ANG_PI;
        end
    end

    // Bypass items carry x = y = 0, which the stages would rotate; mark them.
    logic bypass_reg [NS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]      <= x_next;
            y_reg[0]      <= y_next;
            z_reg[0]      <= z_next;
            bypass_reg[0] <= (y == '0) || (x == '0);
        end
    end

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        rmea_pkg::ang_t         zs;

        rmea_cordic_stage #(.XY_W(XY_W), .STEP(i)) u_stage (
            .x_in  (x_reg[i]),
            .y_in  (y_reg[i]),
            .z_in  (z_reg[i]),
            .x_out (xs),
            .y_out (ys),
            .z_out (zs)
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]      <= xs;
                y_reg[i+1]      <= ys;
                z_reg[i+1]      <= bypass_reg[i] ? z_reg[i] : zs;
                bypass_reg[i+1] <= bypass_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= rmea_pkg::to_q13(z_reg[NS]);
    end

    assign angle = angle_reg;
endmodule

// ----- sv/rotation_matrix_to_euler_angles_top.sv -----
// One item per cycle unless the output stalls; the pipe holds these registers:
// squares (1), root stages of two radicand bits each (DATA_WIDTH+1), fold, CORDIC and
// rounding (min(CORDIC_STAGES, TABLE_LEN)+2) and a one-entry output register (1).
// A stall freezes the whole pipe; ready drops only while the output stays full.
// rst_n (asynchronous, active low) clears valid bits and sets the threshold to 1.
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_top
// Z-Y-X Euler angles from a Q2.14 rotation matrix, with gimbal-lock fallback.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_top #(
    parameter int DATA_WIDTH    = rmea_pkg::DATA_WIDTH_DEF,
    parameter int CORDIC_STAGES = rmea_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rmea_in_if.sink     in_ch,
    rmea_out_if.source  out_ch,
    rmea_cfg_if.sink    cfg
);
    localparam int SQ_W  = 2*DATA_WIDTH + 2;
    localparam int RT_W  = DATA_WIDTH + 1;
    localparam int NSQ   = SQ_W / 2;
    localparam int A_W   = DATA_WIDTH + 2;
    localparam int NCS   = (CORDIC_STAGES < rmea_pkg::TABLE_LEN) ?
                           CORDIC_STAGES : rmea_pkg::TABLE_LEN;
    localparam int LAT_C = NCS + 2;
    localparam int OW    = rmea_pkg::OUT_W;

    logic en;
    logic [rmea_pkg::THR_W-1:0] thr_reg;

    // Threshold register.
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= rmea_pkg::THR_RESET;
        else if (cfg.valid)
            thr_reg <= cfg.singular_threshold;
    end

    // ---------------- squares (stage 0) ----------------
    logic signed [DATA_WIDTH-1:0] m_reg [NSQ+1][7];
    logic [SQ_W-1:0] sum_reg;
    logic v_reg [NSQ+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0][0] <= in_ch.m00;
            m_reg[0][1] <= in_ch.m10;
            m_reg[0][2] <= in_ch.m20;
            m_reg[0][3] <= in_ch.m21;
            m_reg[0][4] <= in_ch.m22;
            m_reg[0][5] <= in_ch.m11;
            m_reg[0][6] <= in_ch.m12;
            sum_reg <= SQ_W'(in_ch.m00 * in_ch.m00) + SQ_W'(in_ch.m10 * in_ch.m10);
        end
    end

    // ---------------- square root stages ----------------
    logic [SQ_W-1:0] rem_reg  [NSQ+1];
    logic [RT_W-1:0] root_reg [NSQ+1];

    assign rem_reg[0]  = sum_reg;
    assign root_reg[0] = '0;

    for (genvar s = 0; s < NSQ; s++)
    begin : g_sqrt
        logic [SQ_W-1:0] rem_n;
        logic [RT_W-1:0] root_n;
        logic [SQ_W-1:0] rem_q;
        logic [RT_W-1:0] root_q;

        rmea_isqrt_stage #(.SQ_W(SQ_W), .RT_W(RT_W), .STEP(s)) u_sq (
            .rem_in   (rem_reg[s]),
            .root_in  (root_reg[s]),
            .rem_out  (rem_n),
            .root_out (root_n)
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_q  <= rem_n;
                root_q <= root_n;
                m_reg[s+1] <= m_reg[s];
            end
        end
        assign rem_reg[s+1]  = rem_q;
        assign root_reg[s+1] = root_q;
    end

    // ---------------- selection, into the CORDIC units ----------------
    logic sing;
    logic signed [A_W-1:0] xy_y, xy_x, yy, yx, zy, zx;
    logic sing_reg [LAT_C];

    assign sing = root_reg[NSQ] < RT_W'(thr_reg);

    always_comb
    begin
        yy = -A_W'(m_reg[NSQ][2]);
        yx = A_W'(root_reg[NSQ]);
        zy = A_W'(m_reg[NSQ][1]);
        zx = A_W'(m_reg[NSQ][0]);
        if (sing)
        begin
            xy_y = -A_W'(m_reg[NSQ][6]);
            xy_x = A_W'(m_reg[NSQ][5]);
        end
        else
        begin
            xy_y = A_W'(m_reg[NSQ][3]);
            xy_x = A_W'(m_reg[NSQ][4]);
        end
    end

    logic signed [OW-1:0] ax, ay, az;

    rmea_atan2 #(.IN_W(A_W), .CORDIC_STAGES(CORDIC_STAGES)) u_ax (
        .clk(clk), .en(en), .y(xy_y), .x(xy_x), .angle(ax));
    rmea_atan2 #(.IN_W(A_W), .CORDIC_STAGES(CORDIC_STAGES)) u_ay (
        .clk(clk), .en(en), .y(yy), .x(yx), .angle(ay));
    rmea_atan2 #(.IN_W(A_W), .CORDIC_STAGES(CORDIC_STAGES)) u_az (
        .clk(clk), .en(en), .y(zy), .x(zx), .angle(az));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg[0] <= sing;
            for (int k = 1; k < LAT_C; k++)
                sing_reg[k] <= sing_reg[k-1];
        end
    end

    // ---------------- valid chain ----------------
    logic vc_reg [LAT_C];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NSQ; k++)
                v_reg[k] <= 1'b0;
            for (int k = 0; k < LAT_C; k++)
                vc_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_ch.valid;
            for (int k = 1; k <= NSQ; k++)
                v_reg[k] <= v_reg[k-1];
            vc_reg[0] <= v_reg[NSQ];
            for (int k = 1; k < LAT_C; k++)
                vc_reg[k] <= vc_reg[k-1];
        end
    end

    // ---------------- output register ----------------
    logic out_v_reg;
    logic signed [OW-1:0] ox_reg, oy_reg, oz_reg;
    logic os_reg;

    // Advance when the output slot is empty or being drained.
    assign en = !out_v_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vc_reg[LAT_C-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= ax;
            oy_reg <= ay;
            oz_reg <= sing_reg[LAT_C-1] ? '0 : az;
            os_reg <= sing_reg[LAT_C-1];
        end
    end

    assign out_ch.valid       = out_v_reg;
    assign out_ch.angle_x     = DATA_WIDTH'(ox_reg);
    assign out_ch.angle_y     = DATA_WIDTH'(oy_reg);
    assign out_ch.angle_z     = DATA_WIDTH'(oz_reg);
    assign out_ch.is_singular = os_reg;
endmodule

// ----- sv/rmea_checker.sv -----
// ----------------------------------------------------------------------------
// rmea_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_euler_angles_top_defines.svh"

module rmea_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic signed [15:0] angle_z,
    input logic signed [15:0] angle_x,
    input logic        is_singular
);
    `RMEA_ASSERT_IMPL(a_sing_z, clk, rst_n, out_valid && is_singular, angle_z == 16'sd0, "singular result with nonzero z")
    `RMEA_ASSERT_IMPL(a_x_range, clk, rst_n, out_valid, (angle_x <= 16'sd25736) && (angle_x >= -16'sd25736), "angle_x out of range")
    `RMEA_ASSERT_IMPL(a_ready, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled with free output")
    `RMEA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(angle_x), "stalled result changed")
endmodule

bind rotation_matrix_to_euler_angles_top rmea_checker u_rmea_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .angle_z     (out_ch.angle_z),
    .angle_x     (out_ch.angle_x),
    .is_singular (out_ch.is_singular)
);

// ----- tb/rmea_tb_if.sv -----
// ----------------------------------------------------------------------------
// rmea_tb_if
// Clock and reset wires shared by the testbench processes.
// ----------------------------------------------------------------------------
interface rmea_tb_clk_if;
    logic clk;
    logic rst_n;
endinterface

// ----- tb/tb_rotation_matrix_to_euler_angles_top.sv -----
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_euler_angles_top
// Drives matrices into the Euler angle converter with random idle cycles on
// both channels, predicts each angle triple with a bit-exact fixed-point
// CORDIC model, and compares the results in order. The singular threshold is
// rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_euler_angles_top;

    localparam int DW     = 16;
    localparam int STAGES = 16;
    localparam int LAT    = DW + STAGES + 5;

    typedef logic signed [DW-1:0] word_t;

    typedef struct {
        word_t ax;
        word_t ay;
        word_t az;
        logic  sing;
    } euler_t;

    class euler_scoreboard;
        logic [rmea_pkg::THR_W-1:0] thr;
        euler_t           pending[$];
        int               errors;

        function new();
            thr    = rmea_pkg::THR_RESET;
            errors = 0;
        endfunction

        static function longint fshift(longint v, int k);
            return v >>> k;
        endfunction

        static function longint q13(longint z);
            longint r;
            r = fshift(z + 1024, 11);
            if (r > 25736)
                r = 25736;
            if (r < -25736)
                r = -25736;
            return r;
        endfunction

        static function longint atan_step(int i);
            longint t[8];
            t = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
            if (i < 8)
                return t[i];
            return longint'(65536) >> (i - 8);
        endfunction

        static function word_t arctan2(longint y, longint x);
            longint z;
            longint dx;
            longint dy;
            z = 0;
            if (y == 0)
                return word_t'(x >= 0 ? 0 : q13(52707179));
            if (x == 0)
                return word_t'(q13(y > 0 ? 26353589 : -26353589));
            if (x < 0)
            begin
                z = y > 0 ? 52707179 : -52707179;
                x = -x;
                y = -y;
            end
            x = x * 65536;
            y = y * 65536;
            for (int i = 0; i < STAGES; i++)
            begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (y >= 0)
                begin
                    x += dx;
                    y -= dy;
                    z += atan_step(i);
                end
                else
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_step(i);
                end
            end
            return word_t'(q13(z));
        endfunction

        function void note_matrix(word_t m[7]);
            longint sq;
            longint sy;
            euler_t e;
            sq = longint'(m[0]) * m[0] + longint'(m[1]) * m[1];
            sy = 0;
            // largest root with sy*sy <= sq
            for (int b = 16; b >= 0; b--)
                if ((sy + (longint'(1) << b)) * (sy + (longint'(1) << b)) <= sq)
                    sy += longint'(1) << b;
            e.sing = sy < thr;
            e.ay   = arctan2(-longint'(m[2]), sy);
            if (!e.sing)
            begin
                e.ax = arctan2(m[3], m[4]);
                e.az = arctan2(m[1], m[0]);
            end
            else
            begin
                e.ax = arctan2(-longint'(m[6]), m[5]);
                e.az = '0;
            end
            pending.insert(pending.size(), e);
        endfunction

        function void check_angles(word_t ax, word_t ay, word_t az, logic sing);
            euler_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ax !== e.ax)
            begin
                $error("angle_x expected %0d actual %0d", e.ax, ax);
                errors++;
            end
            if (ay !== e.ay)
            begin
                $error("angle_y expected %0d actual %0d", e.ay, ay);
                errors++;
            end
            if (az !== e.az)
            begin
                $error("angle_z expected %0d actual %0d", e.az, az);
                errors++;
            end
            if (sing !== e.sing)
            begin
                $error("is_singular expected %0d actual %0d", e.sing, sing);
                errors++;
            end
        endfunction
    endclass

    rmea_tb_clk_if      sys();
    rmea_in_if  #(DW)   in_ch();
    rmea_out_if #(DW)   out_ch();
    rmea_cfg_if         cfg();

    rotation_matrix_to_euler_angles_top #(.DATA_WIDTH(DW), .CORDIC_STAGES(STAGES)) u_top (
        .clk   (sys.clk),
        .rst_n (sys.rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg   (cfg)
    );

    euler_scoreboard sb;
    int              src_idle;
    int              snk_idle;

    initial
    begin
        sys.clk = 1'b0;
        forever #10 sys.clk = ~sys.clk;
    end

    initial
    begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    // result side: random stall, check on every transfer
    always @(posedge sys.clk)
    begin
        if (sys.rst_n && out_ch.valid && out_ch.ready)
            sb.check_angles(out_ch.angle_x, out_ch.angle_y, out_ch.angle_z,
                            out_ch.is_singular);
        out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end

    function automatic word_t rand_elem();
        case ($urandom_range(9))
            0: return word_t'(16384);
            1: return word_t'(-16384);
            2: return '0;
            3: return word_t'($urandom);            // any pattern, also out of range
            4: return word_t'($signed($urandom_range(64)) - 32);
            default: return word_t'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    task automatic send_matrix(word_t m[7]);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge sys.clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.m00 <= m[0];
        in_ch.m10 <= m[1];
        in_ch.m20 <= m[2];
        in_ch.m21 <= m[3];
        in_ch.m22 <= m[4];
        in_ch.m11 <= m[5];
        in_ch.m12 <= m[6];
        @(posedge sys.clk);
        while (!in_ch.ready)
            @(posedge sys.clk);
        sb.note_matrix(m);
    endtask

    task automatic write_threshold(logic [rmea_pkg::THR_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge sys.clk);
        repeat (LAT + 4) @(posedge sys.clk);
        cfg.valid              <= 1'b1;
        cfg.singular_threshold <= v;
        @(posedge sys.clk);
        while (!cfg.ready)
            @(posedge sys.clk);
        cfg.valid <= 1'b0;
        sb.thr = v;
    endtask

    task automatic random_items(int n);
        word_t m[7];
        for (int k = 0; k < n; k++)
        begin
            foreach (m[j])
                m[j] = rand_elem();
            // drive toward the gimbal-lock boundary often
            if ($urandom_range(3) == 0)
            begin
                m[0] = word_t'($signed($urandom_range(600)) - 300);
                m[1] = word_t'($signed($urandom_range(600)) - 300);
            end
            send_matrix(m);
        end
    endtask

    initial
    begin
        word_t m[7];
        word_t ext[4];
        sb = new();
        src_idle = 16;
        snk_idle = 75;
        sys.rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.m00 = '0;
        in_ch.m10 = '0;
        in_ch.m20 = '0;
        in_ch.m21 = '0;
        in_ch.m22 = '0;
        in_ch.m11 = '0;
        in_ch.m12 = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.singular_threshold = '0;
        repeat (5) @(posedge sys.clk);
        sys.rst_n <= 1'b1;
        @(posedge sys.clk);

        // directed: identity, zero matrix, axis signs, extremes
        ext = '{word_t'(16384), word_t'(-16384), '0, word_t'(-32768)};
        m = '{word_t'(16384), 0, 0, 0, word_t'(16384), word_t'(16384), 0};
        send_matrix(m);
        m = '{0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++)
            begin
                m = '{ext[a], ext[b], ext[b], ext[a], ext[b], ext[a], ext[b]};
                send_matrix(m);
            end
        m = '{0, 0, word_t'(-16384), word_t'(5000), 0, word_t'(-3), word_t'(7)};
        send_matrix(m);
        m = '{word_t'(-1), word_t'(1), word_t'(16384), 0, word_t'(-1), 0, word_t'(-5)};
        send_matrix(m);
        m = '{word_t'(32767), word_t'(32767), word_t'(32767), word_t'(-1), word_t'(-32768),
              word_t'(-1), word_t'(32767)};
        send_matrix(m);

        random_items(400);
        write_threshold(15'd16384);
        random_items(250);
        write_threshold('0);
        src_idle = 75;
        snk_idle = 16;
        random_items(300);
        write_threshold(15'd32767);
        random_items(200);
        write_threshold(15'd200);
        src_idle = 0;
        snk_idle = 0;
        random_items(380);
        in_ch.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge sys.clk);
        repeat (LAT + 4) @(posedge sys.clk);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/rmea_pkg.sv
sv/rmea_if.sv
sv/rmea_isqrt_stage.sv
sv/rmea_cordic_stage.sv
sv/rmea_atan2.sv
sv/rotation_matrix_to_euler_angles_top.sv
sv/rmea_checker.sv
tb/rmea_tb_if.sv
tb/tb_rotation_matrix_to_euler_angles_top.sv
